// ----- rtl/lz4s_sequence_extractor_assert.svh -----
// Assertion macros shared by the LZ4s sequence extractor RTL.
`ifndef LZ4S_SEQUENCE_EXTRACTOR_ASSERT_SVH
`define LZ4S_SEQUENCE_EXTRACTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Whenever ante holds, cons must hold in the same cycle.
`define LZ4S_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lz4s assertion failed");

// cond must never hold.
`define LZ4S_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lz4s assertion failed");

`else

`define LZ4S_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LZ4S_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- rtl/lz4s_pkg.sv -----
// Shared types, constants and helpers of the LZ4s sequence extractor.
package lz4s_pkg;

    localparam int LEN_W      = 17;
    localparam int DIST_W     = 16;
    localparam int BIAS_W     = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [BIAS_W-1:0] BIAS_RESET = 2'd2;

    // One parsed input byte's worth of work for the emitter.
    typedef struct packed {
        logic              seq_valid;
        logic [DIST_W-1:0] seq_dist;
        logic [LEN_W-1:0]  seq_lit;
        logic [LEN_W-1:0]  seq_match;
        logic              delim_valid;
        logic [LEN_W-1:0]  delim_lit;
        logic              delim_malformed;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [LEN_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[LEN_W] ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
    endfunction

endpackage

// ----- rtl/lz4s_parser.sv -----
// Front end: byte parser of LZ4s tokens, lengths and offsets, builds jobs.
module lz4s_parser
    import lz4s_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_block_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [BIAS_W-1:0] i_cfg_data,
    input  t_q_stat           i_q_stat,
    output logic              o_push,
    output t_job              o_job
);

    localparam logic [2:0] PH_TOKEN     = 3'd0;
    localparam logic [2:0] PH_LIT_EXT   = 3'd1;
    localparam logic [2:0] PH_LITERALS  = 3'd2;
    localparam logic [2:0] PH_OFF_LO    = 3'd3;
    localparam logic [2:0] PH_OFF_HI    = 3'd4;
    localparam logic [2:0] PH_MATCH_EXT = 3'd5;

    localparam logic [LEN_W-1:0] NIBBLE_EXT = LEN_W'(15);

    logic [BIAS_W-1:0] r_bias;
    logic [2:0]        r_phase,   n_phase;
    logic [3:0]        r_nibble,  n_nibble;
    logic [LEN_W-1:0]  r_run,     n_run;
    logic [LEN_W-1:0]  r_pend,    n_pend;
    logic [LEN_W-1:0]  r_skip,    n_skip;
    logic [7:0]        r_off_lo,  n_off_lo;
    logic [DIST_W-1:0] r_off,     n_off;
    logic [LEN_W-1:0]  r_mcount,  n_mcount;

    logic             accept;
    logic [LEN_W-1:0] byte_ext;
    logic [LEN_W-1:0] skip_dec;
    logic             finish;
    t_job             job;

    assign accept      = i_in_valid && !i_q_stat.full;
    assign o_in_stall  = i_q_stat.full;
    assign o_cfg_ready = 1'b1;
    assign byte_ext    = {{(LEN_W-8){1'b0}}, i_data_byte};
    assign skip_dec    = (r_skip != '0) ? r_skip - LEN_W'(1) : '0;

    always_comb begin
        n_phase  = r_phase;
        n_nibble = r_nibble;
        n_run    = r_run;
        n_pend   = r_pend;
        n_skip   = r_skip;
        n_off_lo = r_off_lo;
        n_off    = r_off;
        n_mcount = r_mcount;
        finish   = 1'b0;
        job      = '0;

        case (r_phase)
            PH_TOKEN: begin
                n_nibble = i_data_byte[3:0];
                n_run    = {{(LEN_W-4){1'b0}}, i_data_byte[7:4]};
                if (i_data_byte[7:4] == 4'hF) begin
                    n_phase = PH_LIT_EXT;
                end else begin
                    n_skip  = n_run;
                    n_phase = (n_run != '0) ? PH_LITERALS : PH_OFF_LO;
                end
            end
            PH_LIT_EXT: begin
                n_run = sat_add(r_run, byte_ext);
                if (i_data_byte != 8'hFF) begin
                    n_skip  = n_run;
                    n_phase = (n_run != '0) ? PH_LITERALS : PH_OFF_LO;
                end
            end
            PH_LITERALS: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    n_phase = PH_OFF_LO;
                end
            end
            PH_OFF_LO: begin
                n_off_lo = i_data_byte;
                n_phase  = PH_OFF_HI;
            end
            PH_OFF_HI: begin
                n_off = {i_data_byte, r_off_lo};
                if (r_nibble == 4'hF) begin
                    n_mcount = NIBBLE_EXT;
                    n_phase  = PH_MATCH_EXT;
                end else begin
                    n_mcount = {{(LEN_W-4){1'b0}}, r_nibble};
                    finish   = 1'b1;
                end
            end
            PH_MATCH_EXT: begin
                n_mcount = sat_add(r_mcount, byte_ext);
                finish   = (i_data_byte != 8'hFF);
            end
            default: begin
                n_phase = PH_TOKEN;
            end
        endcase

        // Close the sequence: emit it, or carry its literals forward.
        if (finish) begin
            if (n_mcount != '0) begin
                job.seq_valid = 1'b1;
                job.seq_dist  = n_off;
                job.seq_lit   = sat_add(r_pend, r_run);
                job.seq_match = sat_add(n_mcount, {{(LEN_W-BIAS_W){1'b0}}, r_bias});
                n_pend        = '0;
            end else begin
                n_pend = sat_add(r_pend, r_run);
            end
            n_run   = '0;
            n_phase = PH_TOKEN;
        end

        // Block end: delimiter, then drop all parse state.
        if (i_block_last) begin
            job.delim_valid = 1'b1;
            if (n_phase == PH_TOKEN) begin
                job.delim_lit = n_pend;
            end else if (n_phase == PH_OFF_LO) begin
                job.delim_lit = sat_add(n_pend, n_run);
            end else begin
                job.delim_lit       = n_pend;
                job.delim_malformed = 1'b1;
            end
            n_phase  = PH_TOKEN;
            n_nibble = '0;
            n_run    = '0;
            n_pend   = '0;
            n_skip   = '0;
            n_off_lo = '0;
            n_off    = '0;
            n_mcount = '0;
        end
    end

    assign o_push = accept && (job.seq_valid || job.delim_valid);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias   <= BIAS_RESET;
            r_phase  <= PH_TOKEN;
            r_nibble <= '0;
            r_run    <= '0;
            r_pend   <= '0;
            r_skip   <= '0;
            r_off_lo <= '0;
            r_off    <= '0;
            r_mcount <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_bias <= i_cfg_data;
            end
            if (accept) begin
                r_phase  <= n_phase;
                r_nibble <= n_nibble;
                r_run    <= n_run;
                r_pend   <= n_pend;
                r_skip   <= n_skip;
                r_off_lo <= n_off_lo;
                r_off    <= n_off;
                r_mcount <= n_mcount;
            end
        end
    end

endmodule

// ----- rtl/lz4s_job_fifo.sv -----
// Short job queue between the parser and the record emitter.
`include "lz4s_sequence_extractor_assert.svh"

module lz4s_job_fifo
    import lz4s_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (FIFO_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (FIFO_AW+1)'(1);
            end
        end
    end

    `LZ4S_ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && o_stat.full)
    `LZ4S_ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && o_stat.empty)
    `LZ4S_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > (FIFO_AW+1)'(FIFO_DEPTH))

endmodule

// ----- rtl/lz4s_emitter.sv -----
// Back end: expands queued jobs into sequence and delimiter records.
`include "lz4s_sequence_extractor_assert.svh"

module lz4s_emitter
    import lz4s_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_job              i_head,
    input  t_q_stat           i_q_stat,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DIST_W-1:0] o_match_distance,
    output logic [LEN_W-1:0]  o_literal_length,
    output logic [LEN_W-1:0]  o_match_length,
    output logic              o_is_delimiter,
    output logic              o_last_of_run,
    output logic              o_malformed
);

    logic              r_valid;
    logic              r_second;
    logic [DIST_W-1:0] r_dist;
    logic [LEN_W-1:0]  r_lit;
    logic [LEN_W-1:0]  r_match;
    logic              r_delim;
    logic              r_last;
    logic              r_mal;

    logic load;
    logic split_first;
    logic take_delim;

    assign load        = !r_valid || !i_out_stall;
    // First half of a two-record job: show the sequence, keep the job.
    assign split_first = i_head.seq_valid && i_head.delim_valid && !r_second;
    assign take_delim  = r_second || !i_head.seq_valid;
    assign o_pop       = load && !i_q_stat.empty && !split_first;

    always_ff @(posedge i_clk) begin
        if (load && !i_q_stat.empty) begin
            r_last <= !split_first;
            if (!split_first && take_delim) begin
                r_dist  <= '0;
                r_lit   <= i_head.delim_lit;
                r_match <= '0;
                r_delim <= 1'b1;
                r_mal   <= i_head.delim_malformed;
            end else begin
                r_dist  <= i_head.seq_dist;
                r_lit   <= i_head.seq_lit;
                r_match <= i_head.seq_match;
                r_delim <= 1'b0;
                r_mal   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_stat.empty;
            if (!i_q_stat.empty) begin
                r_second <= split_first;
            end
        end
    end

    assign o_out_valid      = r_valid;
    assign o_match_distance = r_dist;
    assign o_literal_length = r_lit;
    assign o_match_length   = r_match;
    assign o_is_delimiter   = r_delim;
    assign o_last_of_run    = r_last;
    assign o_malformed      = r_mal;

    `LZ4S_ASSERT_IMP(a_head_has_record, i_clk, i_rst_n, !i_q_stat.empty,
        i_head.seq_valid || i_head.delim_valid)
    `LZ4S_ASSERT_IMP(a_second_is_delim, i_clk, i_rst_n, r_second,
        !i_q_stat.empty && i_head.delim_valid)

endmodule

// ----- rtl/lz4s_sequence_extractor.sv -----
// Top level of the LZ4s sequence extractor: parser, job queue and emitter.
//
// The block takes one byte of an LZ4s block per cycle and turns it into
// zstd-style sequence records (offset, literal length, match length) plus
// one delimiter record per block that carries the trailing literals and a
// malformed flag when the block ends inside a length, literal run or
// offset. Every byte is parsed in the cycle it is accepted, so the input
// side sustains one item per clock. A byte produces zero, one or two
// records; the emitter drives one record per clock from its output
// register while the output is not stalled, so a byte that closes a
// sequence on the block's last byte gives the output side two records.
// A four-entry job queue between parser and emitter absorbs those bursts
// and output stalls; the input stalls only while that queue is full.
// Results pass through the job queue and the emitter's output register.
// Lengths are 17 bits and saturate at all ones. The match length bias
// register (reset 2) is written on the cfg channel, which is always
// ready; write it only while the block is idle.
module lz4s_sequence_extractor
    import lz4s_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte input
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_block_last,
    // configuration: match length bias
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [BIAS_W-1:0] i_cfg_data,
    // record output
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DIST_W-1:0] o_match_distance,
    output logic [LEN_W-1:0]  o_literal_length,
    output logic [LEN_W-1:0]  o_match_length,
    output logic              o_is_delimiter,
    output logic              o_last_of_run,
    output logic              o_malformed
);

    t_job    push_job;
    t_job    head_job;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    // Parse each accepted byte and hand finished records to the queue.
    lz4s_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_block_last (i_block_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_job        (push_job)
    );

    // Decouple parsing from output back-pressure.
    lz4s_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    // Drain jobs one record per cycle while the output is not stalled.
    lz4s_emitter u_emitter (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head_job),
        .i_q_stat         (q_stat),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_match_distance (o_match_distance),
        .o_literal_length (o_literal_length),
        .o_match_length   (o_match_length),
        .o_is_delimiter   (o_is_delimiter),
        .o_last_of_run    (o_last_of_run),
        .o_malformed      (o_malformed)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the LZ4s sequence extractor: byte driver, record monitor, predictor.
module tb_top;
    import lz4s_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_PRINTS   = 40;
    localparam int PHASE_ITEMS  = 180;
    localparam int NUM_PHASES   = 4;

    localparam logic [LEN_W-1:0] LEN_MAX  = {LEN_W{1'b1}};
    localparam logic [7:0]       EXT_MORE = 8'hFF;   // length extension continues
    localparam logic [3:0]       NIB_EXT  = 4'hF;    // nibble that opens an extension
    localparam int               NIB_FULL = 15;
    localparam int               EXT_STEP = 255;

    // Parse position of the predictor, one per kind of byte in the stream.
    typedef enum logic [2:0] {
        ST_TOKEN,
        ST_LIT_EXT,
        ST_LITERALS,
        ST_OFF_LO,
        ST_OFF_HI,
        ST_MATCH_EXT
    } t_parse_state;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    typedef struct packed {
        logic [DIST_W-1:0] match_distance;
        logic [LEN_W-1:0]  literal_length;
        logic [LEN_W-1:0]  match_length;
        logic              is_delimiter;
        logic              last_of_run;
        logic              malformed;
    } t_seq_record;

    // ------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value.
    // ------------------------------------------------------------------
    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_stall;
    logic [7:0]        i_data_byte  = '0;
    logic              i_block_last = 1'b0;
    logic              i_cfg_valid  = 1'b0;
    logic              o_cfg_ready;
    logic [BIAS_W-1:0] i_cfg_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall  = 1'b0;
    logic [DIST_W-1:0] o_match_distance;
    logic [LEN_W-1:0]  o_literal_length;
    logic [LEN_W-1:0]  o_match_length;
    logic              o_is_delimiter;
    logic              o_last_of_run;
    logic              o_malformed;

    always #2 i_clk = ~i_clk;

    lz4s_sequence_extractor uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_block_last     (i_block_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_match_distance (o_match_distance),
        .o_literal_length (o_literal_length),
        .o_match_length   (o_match_length),
        .o_is_delimiter   (o_is_delimiter),
        .o_last_of_run    (o_last_of_run),
        .o_malformed      (o_malformed)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    t_byte_item  pending_bytes[$];     // bytes waiting for the driver
    t_byte_item  block_bytes[$];       // block under construction
    t_seq_record expected_records[$];  // records the block still owes
    t_seq_record step_records[$];      // records of the byte being predicted

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int bytes_accepted = 0;
    int seq_seen       = 0;
    int delim_seen     = 0;
    int malformed_seen = 0;
    int saturated_seen = 0;

    // Predictor copy of the register and of the parse state.
    logic [BIAS_W-1:0] bias_reg       = BIAS_RESET;
    t_parse_state      ps_state       = ST_TOKEN;
    logic [3:0]        ps_match_nib   = '0;
    logic [LEN_W-1:0]  ps_run         = '0;
    logic [LEN_W-1:0]  ps_carry       = '0;
    logic [LEN_W-1:0]  ps_skip        = '0;
    logic [7:0]        ps_off_lo      = '0;
    logic [DIST_W-1:0] ps_offset      = '0;
    logic [LEN_W-1:0]  ps_match_count = '0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [LEN_W-1:0] len_sat_add(input logic [LEN_W-1:0] a,
                                                     input logic [LEN_W-1:0] b);
        logic [LEN_W:0] total;
        total = a + b;
        return (total > LEN_MAX) ? LEN_MAX : total[LEN_W-1:0];
    endfunction

    function automatic t_seq_record make_record(input logic [DIST_W-1:0] match_dist,
                                                input logic [LEN_W-1:0] lits,
                                                input logic [LEN_W-1:0] mlen,
                                                input logic delim, input logic mal);
        t_seq_record r;
        r.match_distance = match_dist;
        r.literal_length = lits;
        r.match_length   = mlen;
        r.is_delimiter   = delim;
        r.last_of_run    = 1'b0;
        r.malformed      = mal;
        return r;
    endfunction

    // Close the current sequence: emit it when it has a match, else carry its literals.
    task automatic close_sequence();
        if (ps_match_count != '0) begin
            step_records.push_back(make_record(ps_offset, len_sat_add(ps_carry, ps_run),
                                               len_sat_add(ps_match_count, LEN_W'(bias_reg)),
                                               1'b0, 1'b0));
            ps_carry = '0;
        end else begin
            ps_carry = len_sat_add(ps_carry, ps_run);
        end
        ps_run   = '0;
        ps_state = ST_TOKEN;
    endtask

    task automatic clear_parse();
        ps_state       = ST_TOKEN;
        ps_match_nib   = '0;
        ps_run         = '0;
        ps_carry       = '0;
        ps_skip        = '0;
        ps_off_lo      = '0;
        ps_offset      = '0;
        ps_match_count = '0;
    endtask

    // Advance the parse by one accepted byte and queue the records it causes.
    task automatic predict_records(input logic [7:0] b, input logic last);
        step_records.delete();
        case (ps_state)
            ST_TOKEN: begin
                ps_match_nib = b[3:0];
                ps_run       = LEN_W'(b[7:4]);
                if (b[7:4] == NIB_EXT) begin
                    ps_state = ST_LIT_EXT;
                end else begin
                    ps_skip  = ps_run;
                    ps_state = (ps_run != '0) ? ST_LITERALS : ST_OFF_LO;
                end
            end
            ST_LIT_EXT: begin
                ps_run = len_sat_add(ps_run, LEN_W'(b));
                if (b != EXT_MORE) begin
                    ps_skip  = ps_run;
                    ps_state = (ps_run != '0) ? ST_LITERALS : ST_OFF_LO;
                end
            end
            ST_LITERALS: begin
                if (ps_skip != '0)
                    ps_skip = ps_skip - 1'b1;
                if (ps_skip == '0)
                    ps_state = ST_OFF_LO;
            end
            ST_OFF_LO: begin
                ps_off_lo = b;
                ps_state  = ST_OFF_HI;
            end
            ST_OFF_HI: begin
                ps_offset = {b, ps_off_lo};
                if (ps_match_nib == NIB_EXT) begin
                    ps_match_count = LEN_W'(NIB_FULL);
                    ps_state       = ST_MATCH_EXT;
                end else begin
                    ps_match_count = LEN_W'(ps_match_nib);
                    close_sequence();
                end
            end
            ST_MATCH_EXT: begin
                ps_match_count = len_sat_add(ps_match_count, LEN_W'(b));
                if (b != EXT_MORE)
                    close_sequence();
            end
            default: ps_state = ST_TOKEN;
        endcase

        // Block end: a clean end carries the literals, a cut one drops the partial sequence.
        if (last) begin
            if (ps_state == ST_TOKEN)
                step_records.push_back(make_record('0, ps_carry, '0, 1'b1, 1'b0));
            else if (ps_state == ST_OFF_LO)
                step_records.push_back(make_record('0, len_sat_add(ps_carry, ps_run), '0,
                                                   1'b1, 1'b0));
            else
                step_records.push_back(make_record('0, ps_carry, '0, 1'b1, 1'b1));
            clear_parse();
        end

        if (step_records.size() > 0)
            step_records[step_records.size() - 1].last_of_run = 1'b1;
        foreach (step_records[i])
            expected_records.push_back(step_records[i]);
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting: one line per fault, printing capped, counting not.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Byte driver: hold a stalled item, advance on acceptance, idle at random.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_byte_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_records(i_data_byte, i_block_last);
                bytes_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_bytes.pop_front();
                    i_in_valid   <= 1'b1;
                    i_data_byte  <= nxt.data;
                    i_block_last <= nxt.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Record monitor: check each accepted record against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_seq_record got;
        t_seq_record want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got.match_distance = o_match_distance;
                got.literal_length = o_literal_length;
                got.match_length   = o_match_length;
                got.is_delimiter   = o_is_delimiter;
                got.last_of_run    = o_last_of_run;
                got.malformed      = o_malformed;
                if (expected_records.size() == 0) begin
                    report_mismatch("record with nothing expected, literal_length",
                                    got.literal_length, 0);
                end else begin
                    want = expected_records.pop_front();
                    if (got.match_distance !== want.match_distance)
                        report_mismatch("match_distance", got.match_distance,
                                        want.match_distance);
                    if (got.literal_length !== want.literal_length)
                        report_mismatch("literal_length", got.literal_length,
                                        want.literal_length);
                    if (got.match_length !== want.match_length)
                        report_mismatch("match_length", got.match_length, want.match_length);
                    if (got.is_delimiter !== want.is_delimiter)
                        report_mismatch("is_delimiter", got.is_delimiter, want.is_delimiter);
                    if (got.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
                    if (got.malformed !== want.malformed)
                        report_mismatch("malformed", got.malformed, want.malformed);
                    if (want.is_delimiter) begin
                        delim_seen++;
                        if (want.malformed)
                            malformed_seen++;
                    end else begin
                        seq_seen++;
                    end
                    if (want.literal_length == LEN_MAX || want.match_length == LEN_MAX)
                        saturated_seen++;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] d, input logic last);
        pending_bytes.push_back('{data: d, last: last});
    endtask

    // Append the 255-continued extension bytes for what is left of a length.
    task automatic add_length_ext(input int rem);
        while (rem >= EXT_STEP) begin
            block_bytes.push_back('{data: EXT_MORE, last: 1'b0});
            rem -= EXT_STEP;
        end
        block_bytes.push_back('{data: 8'(rem), last: 1'b0});
    endtask

    // Append one sequence; without a match part it is the trailing literal run.
    task automatic add_sequence(input int lits, input int mlen, input logic [15:0] match_dist,
                                input bit with_match);
        logic [3:0] lit_nib;
        logic [3:0] m_nib;
        int         nlit;
        lit_nib = (lits >= NIB_FULL) ? NIB_EXT : 4'(lits);
        m_nib   = with_match ? ((mlen >= NIB_FULL) ? NIB_EXT : 4'(mlen)) : 4'($urandom);
        nlit    = (lits > int'(LEN_MAX)) ? int'(LEN_MAX) : lits;
        block_bytes.push_back('{data: {lit_nib, m_nib}, last: 1'b0});
        if (lits >= NIB_FULL)
            add_length_ext(lits - NIB_FULL);
        repeat (nlit)
            block_bytes.push_back('{data: 8'($urandom), last: 1'b0});
        if (with_match) begin
            block_bytes.push_back('{data: match_dist[7:0], last: 1'b0});
            block_bytes.push_back('{data: match_dist[15:8], last: 1'b0});
            if (mlen >= NIB_FULL)
                add_length_ext(mlen - NIB_FULL);
        end
    endtask

    // Mostly short literal runs, now and then one long enough for a 255 extension byte.
    function automatic int pick_literals();
        int r;
        r = $urandom_range(99);
        if (r < 60)      return $urandom_range(0, 6);
        else if (r < 85) return $urandom_range(7, 14);
        else if (r < 97) return $urandom_range(15, 30);
        else             return $urandom_range(255, 290);
    endfunction

    // Zero match lengths carry literals forward; long ones chain 255 bytes.
    function automatic int pick_match();
        int r;
        r = $urandom_range(99);
        if (r < 15)      return 0;
        else if (r < 75) return $urandom_range(1, 14);
        else if (r < 95) return $urandom_range(15, 60);
        else             return $urandom_range(270, 1000);
    endfunction

    // Build one block into block_bytes: noise, clean end, trailing run or cut short.
    task automatic build_random_block();
        int kind;
        int ending;
        int keep;
        block_bytes.delete();
        kind   = $urandom_range(99);
        ending = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 12))
                block_bytes.push_back('{data: 8'($urandom), last: 1'b0});
            keep = block_bytes.size();
        end else begin
            repeat ($urandom_range(1, 4))
                add_sequence(pick_literals(), pick_match(), 16'($urandom), 1'b1);
            if (ending >= 65 && ending < 82)
                add_sequence(pick_literals(), 0, 16'h0, 1'b0);
            keep = block_bytes.size();
            if (ending >= 82)
                keep = $urandom_range(1, block_bytes.size());
        end
        while (block_bytes.size() > keep)
            void'(block_bytes.pop_back());
        block_bytes[keep - 1].last = 1'b1;
    endtask

    task automatic queue_block_range(input int first, input int count);
        for (int i = first; i < first + count; i++)
            pending_bytes.push_back(block_bytes[i]);
    endtask

    // Wait until every byte is taken and every owed record has come back.
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || i_in_valid || expected_records.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic settle();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bias(input logic [BIAS_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        bias_reg = value;
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [BIAS_W-1:0] phase_bias[NUM_PHASES];
        int                phase_send[NUM_PHASES];
        int                phase_recv[NUM_PHASES];
        int                added;
        int                half;
        bit                paused;

        phase_bias = '{2'd2, 2'd0, 2'd1, 2'd3};
        phase_send = '{0, 78, 0, 12};
        phase_recv = '{0, 0, 78, 12};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the top bias, no idling.
        write_bias(2'd3);
        push_byte(8'h00, 1'b1);                        // empty token then block end
        push_byte(8'h11, 1'b0); push_byte(8'hAA, 1'b0);
        push_byte(8'h34, 1'b0); push_byte(8'h12, 1'b0); // plain sequence
        push_byte(8'h10, 1'b0); push_byte(8'h55, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h80, 1'b0); // zero match: carry one literal
        push_byte(8'h0F, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b1); // sequence and delimiter on one byte
        push_byte(8'h30, 1'b0); push_byte(8'h01, 1'b1); // cut inside the literal run
        push_byte(8'hF0, 1'b0); push_byte(8'hFF, 1'b1); // cut inside the literal extension
        push_byte(8'h01, 1'b0); push_byte(8'h10, 1'b1); // cut inside the offset
        push_byte(8'h10, 1'b0); push_byte(8'h7F, 1'b1); // clean end after a literal run
        push_byte(8'h0F, 1'b0); push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b1); // cut inside the match extension
        settle();

        // Random phases: one bias and one idling mix each.
        paused = 1'b0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_bias(phase_bias[ph]);
            send_idle_pct  = phase_send[ph];
            recv_stall_pct = phase_recv[ph];
            added = 0;
            while (added < PHASE_ITEMS) begin
                build_random_block();
                if (ph == NUM_PHASES - 1 && !paused && added >= PHASE_ITEMS / 2
                    && block_bytes.size() > 1) begin
                    // Hold the sender mid-block until every owed record is out.
                    half = block_bytes.size() / 2;
                    queue_block_range(0, half);
                    wait_idle();
                    queue_block_range(half, block_bytes.size() - half);
                    paused = 1'b1;
                end else begin
                    queue_block_range(0, block_bytes.size());
                end
                added += block_bytes.size();
            end
            settle();
        end

        // Saturation: a match extension that runs past the length limit, closed on the
        // block's last byte so a sequence and a delimiter come from one byte.
        write_bias(2'd2);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        block_bytes.delete();
        add_sequence(0, NIB_FULL + EXT_STEP * 515 + 3, 16'hBEEF, 1'b1);
        block_bytes[block_bytes.size() - 1].last = 1'b1;
        queue_block_range(0, block_bytes.size());
        settle();

        if (expected_records.size() != 0)
            report_mismatch("records never produced", 0, expected_records.size());

        $display("Parsed %0d bytes in %0d blocks with bias 0 to 3 and four idling mixes.",
                 bytes_accepted, delim_seen);
        $display("Checked %0d sequences, %0d delimiters (%0d cut short), %0d saturated.",
                 seq_seen, delim_seen, malformed_seen, saturated_seen);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
